// ===== hdl/sm83_alu_pkg.sv =====
// ----------------------------------------------------------------------------
// sm83_alu_pkg
// Operation codes, constants and transaction types of the SM83 ALU and flag unit.
// ----------------------------------------------------------------------------
package sm83_alu_pkg;

	localparam logic [4:0] CMD_ADD    = 5'd0;
	localparam logic [4:0] CMD_ADC    = 5'd1;
	localparam logic [4:0] CMD_SUB    = 5'd2;
	localparam logic [4:0] CMD_SBC    = 5'd3;
	localparam logic [4:0] CMD_AND    = 5'd4;
	localparam logic [4:0] CMD_XOR    = 5'd5;
	localparam logic [4:0] CMD_OR     = 5'd6;
	localparam logic [4:0] CMD_CP     = 5'd7;
	localparam logic [4:0] CMD_INC    = 5'd8;
	localparam logic [4:0] CMD_DEC    = 5'd9;
	localparam logic [4:0] CMD_RLCA   = 5'd10;
	localparam logic [4:0] CMD_RRCA   = 5'd11;
	localparam logic [4:0] CMD_RLA    = 5'd12;
	localparam logic [4:0] CMD_RRA    = 5'd13;
	localparam logic [4:0] CMD_DAA    = 5'd14;
	localparam logic [4:0] CMD_CPL    = 5'd15;
	localparam logic [4:0] CMD_CCF    = 5'd16;
	localparam logic [4:0] CMD_SCF    = 5'd17;
	localparam logic [4:0] CMD_RLC    = 5'd18;
	localparam logic [4:0] CMD_RRC    = 5'd19;
	localparam logic [4:0] CMD_RL     = 5'd20;
	localparam logic [4:0] CMD_RR     = 5'd21;
	localparam logic [4:0] CMD_SLA    = 5'd22;
	localparam logic [4:0] CMD_SRA    = 5'd23;
	localparam logic [4:0] CMD_SWAP   = 5'd24;
	localparam logic [4:0] CMD_SRL    = 5'd25;
	localparam logic [4:0] CMD_BIT    = 5'd26;
	localparam logic [4:0] CMD_RES    = 5'd27;
	localparam logic [4:0] CMD_SET    = 5'd28;
	localparam logic [4:0] CMD_ADD16  = 5'd29;
	localparam logic [4:0] CMD_ADD_SP = 5'd30;

	localparam logic [7:0] DAA_LOW_ADJ  = 8'h06;
	localparam logic [7:0] DAA_HIGH_ADJ = 8'h60;
	localparam logic [7:0] DAA_LIMIT    = 8'h99;
	localparam logic [3:0] DAA_DIGIT_MAX = 4'd9;

	typedef struct packed {
		logic [4:0]  cmd;
		logic [15:0] op_a;
		logic [15:0] op_b;
		logic [2:0]  bit_index;
		logic        flag_z_in;
		logic        flag_n_in;
		logic        flag_h_in;
		logic        flag_c_in;
	} alu_req_t;

	typedef struct packed {
		logic [15:0] result;
		logic        write_result;
		logic        flag_z_out;
		logic        flag_n_out;
		logic        flag_h_out;
		logic        flag_c_out;
	} alu_rsp_t;

endpackage

// ===== hdl/sm83_alu_req_if.sv =====
// ----------------------------------------------------------------------------
// sm83_alu_req_if
// Valid/ready channel carrying one ALU operation per transaction.
// ----------------------------------------------------------------------------
interface sm83_alu_req_if
	import sm83_alu_pkg::*;
();
	logic     valid;
	logic     ready;
	alu_req_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/sm83_alu_rsp_if.sv =====
// ----------------------------------------------------------------------------
// sm83_alu_rsp_if
// Valid/ready channel carrying one ALU result and its flags per transaction.
// ----------------------------------------------------------------------------
interface sm83_alu_rsp_if
	import sm83_alu_pkg::*;
();
	logic     valid;
	logic     ready;
	alu_rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/sm83_alu_flags_unit_top.sv =====
// ----------------------------------------------------------------------------
// sm83_alu_flags_unit_top
// SM83 ALU and flag unit: one operation per transaction, result and new flags.
// Takes one operation every clock cycle while req.ready is high. The request
// lands in an input register, the whole operation settles in one pass of
// adders and multiplexers, and the result is held in an output register
// until the consumer takes it. Ready on the request side stays high while
// the input register is empty or moves into the output register in the same
// cycle, so a stalled consumer backs up at most two transactions.
// ----------------------------------------------------------------------------
module sm83_alu_flags_unit_top
	import sm83_alu_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	sm83_alu_req_if.sink     req,
	sm83_alu_rsp_if.source   rsp
);

	logic     valid_s1;
	logic     valid_s2;
	alu_req_t req_s1;
	alu_rsp_t rsp_s2;
	alu_rsp_t rsp_next;
	logic     load_s2;
	logic     load_s1;

	assign load_s2   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || load_s2;
	assign load_s1   = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (!valid_s2 || rsp.ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			req_s1 <= req.data;
		end
		if (load_s2) begin
			rsp_s2 <= rsp_next;
		end
	end

	sm83_alu_core u_core (
		.req (req_s1),
		.rsp (rsp_next)
	);

	assign rsp.valid = valid_s2;
	assign rsp.data  = rsp_s2;

`ifndef SYNTHESIS
	// a new result only appears after a transaction sat in the input register
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s2) |-> $past(valid_s1))
		else $error("result valid without a preceding input stage");

	// an accepted transaction always occupies the input register next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> valid_s1)
		else $error("accepted transaction lost from input register");

	// back-pressure only when both registers hold work
	assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> (valid_s1 && valid_s2 && !rsp.ready))
		else $error("request stalled with a free register");
`endif

endmodule

// ===== hdl/sm83_alu_core.sv =====
// ----------------------------------------------------------------------------
// sm83_alu_core
// Combinational datapath: result value, write-back enable and new flags.
// ----------------------------------------------------------------------------
module sm83_alu_core
	import sm83_alu_pkg::*;
(
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	logic [7:0]  a8;
	logic [7:0]  b8;
	logic        fz, fn, fh, fc;
	logic        carry_in;
	logic [8:0]  add_sum;
	logic [4:0]  add_half;
	logic [8:0]  sub_diff;
	logic [4:0]  sub_half;
	logic        daa_lo, daa_hi;
	logic [7:0]  daa_adj;
	logic [7:0]  daa_val;
	logic [7:0]  bit_mask;
	logic [16:0] hl_sum;
	logic [12:0] hl_half;
	logic [4:0]  sp_half;
	logic [8:0]  sp_low;
	logic [15:0] sp_sum;

	assign a8 = req.op_a[7:0];
	assign b8 = req.op_b[7:0];
	assign fz = req.flag_z_in;
	assign fn = req.flag_n_in;
	assign fh = req.flag_h_in;
	assign fc = req.flag_c_in;

	assign carry_in = ((req.cmd == CMD_ADC) || (req.cmd == CMD_SBC)) & fc;
	assign add_sum  = {1'b0, a8} + {1'b0, b8} + {8'h00, carry_in};
	assign add_half = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'h0, carry_in};
	// bit 8 / bit 4 of the difference is the borrow
	assign sub_diff = {1'b0, a8} - {1'b0, b8} - {8'h00, carry_in};
	assign sub_half = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'h0, carry_in};

	assign daa_lo  = fh || (!fn && (a8[3:0] > DAA_DIGIT_MAX));
	assign daa_hi  = fc || (!fn && (a8 > DAA_LIMIT));
	assign daa_adj = (daa_lo ? DAA_LOW_ADJ : 8'h00) | (daa_hi ? DAA_HIGH_ADJ : 8'h00);
	assign daa_val = fn ? (a8 - daa_adj) : (a8 + daa_adj);

	assign bit_mask = 8'h01 << req.bit_index;

	assign hl_sum  = {1'b0, req.op_a} + {1'b0, req.op_b};
	assign hl_half = {1'b0, req.op_a[11:0]} + {1'b0, req.op_b[11:0]};

	// flags of the signed sp add come from the unsigned low-byte add
	assign sp_half = {1'b0, req.op_a[3:0]} + {1'b0, b8[3:0]};
	assign sp_low  = {1'b0, req.op_a[7:0]} + {1'b0, b8};
	assign sp_sum  = req.op_a + {{8{b8[7]}}, b8};

	always_comb begin
		logic [7:0] sh;
		logic       sh_c;
		sh   = 8'h00;
		sh_c = fc;
		rsp.result       = 16'h0000;
		rsp.write_result = 1'b1;
		rsp.flag_z_out   = fz;
		rsp.flag_n_out   = fn;
		rsp.flag_h_out   = fh;
		rsp.flag_c_out   = fc;
		case (req.cmd)
			CMD_ADD, CMD_ADC: begin
				rsp.result     = {8'h00, add_sum[7:0]};
				rsp.flag_z_out = (add_sum[7:0] == 8'h00);
				rsp.flag_n_out = 1'b0;
				rsp.flag_h_out = add_half[4];
				rsp.flag_c_out = add_sum[8];
			end
			CMD_SUB, CMD_SBC, CMD_CP: begin
				rsp.result     = {8'h00, sub_diff[7:0]};
				rsp.flag_z_out = (sub_diff[7:0] == 8'h00);
				rsp.flag_n_out = 1'b1;
				rsp.flag_h_out = sub_half[4];
				rsp.flag_c_out = sub_diff[8];
				if (req.cmd == CMD_CP) begin
					rsp.result       = {8'h00, a8};
					rsp.write_result = 1'b0;
				end
			end
			CMD_AND, CMD_XOR, CMD_OR: begin
				if (req.cmd == CMD_AND) begin
					rsp.result = {8'h00, a8 & b8};
				end else if (req.cmd == CMD_XOR) begin
					rsp.result = {8'h00, a8 ^ b8};
				end else begin
					rsp.result = {8'h00, a8 | b8};
				end
				rsp.flag_z_out = (rsp.result[7:0] == 8'h00);
				rsp.flag_n_out = 1'b0;
				rsp.flag_h_out = (req.cmd == CMD_AND);
				rsp.flag_c_out = 1'b0;
			end
			CMD_INC: begin
				rsp.result     = {8'h00, b8 + 8'h01};
				rsp.flag_z_out = (b8 == 8'hff);
				rsp.flag_n_out = 1'b0;
				rsp.flag_h_out = (b8[3:0] == 4'hf);
			end
			CMD_DEC: begin
				rsp.result     = {8'h00, b8 - 8'h01};
				rsp.flag_z_out = (b8 == 8'h01);
				rsp.flag_n_out = 1'b1;
				rsp.flag_h_out = (b8[3:0] == 4'h0);
			end
			CMD_RLCA, CMD_RRCA, CMD_RLA, CMD_RRA: begin
				if (req.cmd == CMD_RLCA) begin
					rsp.result = {8'h00, a8[6:0], a8[7]};
				end else if (req.cmd == CMD_RRCA) begin
					rsp.result = {8'h00, a8[0], a8[7:1]};
				end else if (req.cmd == CMD_RLA) begin
					rsp.result = {8'h00, a8[6:0], fc};
				end else begin
					rsp.result = {8'h00, fc, a8[7:1]};
				end
				rsp.flag_c_out = ((req.cmd == CMD_RLCA) || (req.cmd == CMD_RLA)) ? a8[7] : a8[0];
				rsp.flag_z_out = 1'b0;
				rsp.flag_n_out = 1'b0;
				rsp.flag_h_out = 1'b0;
			end
			CMD_DAA: begin
				rsp.result     = {8'h00, daa_val};
				rsp.flag_z_out = (daa_val == 8'h00);
				rsp.flag_h_out = 1'b0;
				rsp.flag_c_out = daa_hi;
			end
			CMD_CPL: begin
				rsp.result     = {8'h00, ~a8};
				rsp.flag_n_out = 1'b1;
				rsp.flag_h_out = 1'b1;
			end
			CMD_CCF, CMD_SCF: begin
				rsp.result     = {8'h00, a8};
				rsp.flag_n_out = 1'b0;
				rsp.flag_h_out = 1'b0;
				rsp.flag_c_out = (req.cmd == CMD_SCF) ? 1'b1 : ~fc;
			end
			CMD_RLC: begin
				sh   = {b8[6:0], b8[7]};
				sh_c = b8[7];
			end
			CMD_RRC: begin
				sh   = {b8[0], b8[7:1]};
				sh_c = b8[0];
			end
			CMD_RL: begin
				sh   = {b8[6:0], fc};
				sh_c = b8[7];
			end
			CMD_RR: begin
				sh   = {fc, b8[7:1]};
				sh_c = b8[0];
			end
			CMD_SLA: begin
				sh   = {b8[6:0], 1'b0};
				sh_c = b8[7];
			end
			CMD_SRA: begin
				sh   = {b8[7], b8[7:1]};
				sh_c = b8[0];
			end
			CMD_SWAP: begin
				sh   = {b8[3:0], b8[7:4]};
				sh_c = 1'b0;
			end
			CMD_SRL: begin
				sh   = {1'b0, b8[7:1]};
				sh_c = b8[0];
			end
			CMD_BIT: begin
				rsp.result       = {8'h00, b8};
				rsp.write_result = 1'b0;
				rsp.flag_z_out   = ~b8[req.bit_index];
				rsp.flag_n_out   = 1'b0;
				rsp.flag_h_out   = 1'b1;
			end
			CMD_RES: begin
				rsp.result = {8'h00, b8 & ~bit_mask};
			end
			CMD_SET: begin
				rsp.result = {8'h00, b8 | bit_mask};
			end
			CMD_ADD16: begin
				rsp.result     = hl_sum[15:0];
				rsp.flag_n_out = 1'b0;
				rsp.flag_h_out = hl_half[12];
				rsp.flag_c_out = hl_sum[16];
			end
			CMD_ADD_SP: begin
				rsp.result     = sp_sum;
				rsp.flag_z_out = 1'b0;
				rsp.flag_n_out = 1'b0;
				rsp.flag_h_out = sp_half[4];
				rsp.flag_c_out = sp_low[8];
			end
			default: begin
				// unused code: operand a passes, nothing written
				rsp.result       = req.op_a;
				rsp.write_result = 1'b0;
			end
		endcase
		// cb-prefix rotates and shifts share one flag rule
		if (req.cmd inside {[CMD_RLC:CMD_SRL]}) begin
			rsp.result     = {8'h00, sh};
			rsp.flag_z_out = (sh == 8'h00);
			rsp.flag_n_out = 1'b0;
			rsp.flag_h_out = 1'b0;
			rsp.flag_c_out = sh_c;
		end
	end

endmodule
